FILE: src/mst_pkg.sv
// Shared types and constants for the max-tracking stack.
// Used by mst_ctrl, mst_dp and max_tracking_stack; depends on nothing.
package mst_pkg;

    localparam int DATA_W          = 32;
    localparam int ENTRY_COUNT_W   = 7;
    localparam int DEF_STACK_DEPTH = 64;

    typedef enum logic [1:0] {
        OP_PUSH    = 2'd0,
        OP_POP     = 2'd1,
        OP_POP_MAX = 2'd2,
        OP_PEEK    = 2'd3
    } op_t;

    // datapath commands, one per cycle
    typedef enum logic [3:0] {
        CMD_NOP,
        CMD_LOAD,
        CMD_PUSH,
        CMD_POP,
        CMD_POP_MAX,
        CMD_FAIL,
        CMD_SCAN_RD,
        CMD_SCAN_NEXT,
        CMD_SHIFT_RD,
        CMD_SHIFT_WR,
        CMD_SHIFT_END,
        CMD_TOP_RD,
        CMD_CAPTURE
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_TOP_RD,
        ST_DONE
    } state_t;

    typedef struct packed {
        op_t  op;
        logic full;
        logic empty;
        logic max_empty;
        logic scan_hit;
        logic shift_more;
    } status_t;

endpackage

FILE: src/mst_ctrl.sv
// Sequencer for the max-tracking stack: walks each request through the datapath.
// Depends on mst_pkg.
module mst_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  mst_pkg::status_t  status,
    output mst_pkg::cmd_t     cmd
);
    import mst_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   capture;

    // result slot free, or being emptied this cycle
    assign capture = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (status.op == OP_POP_MAX && !status.empty && !status.max_empty)
                    state_next = ST_SCAN_RD;
                else
                    state_next = ST_TOP_RD;
            end
            ST_SCAN_RD:
                state_next = ST_SCAN_CMP;
            ST_SCAN_CMP:
                state_next = status.scan_hit ? ST_SHIFT_RD : ST_SCAN_RD;
            ST_SHIFT_RD:
                state_next = status.shift_more ? ST_SHIFT_WR : ST_TOP_RD;
            ST_SHIFT_WR:
                state_next = ST_SHIFT_RD;
            ST_TOP_RD:
                state_next = ST_DONE;
            ST_DONE:
            begin
                if (capture)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready       = (state_reg == ST_IDLE);
        cmd            = CMD_NOP;
        out_valid_next = out_valid_reg;
        if (capture)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        case (state_reg)
            ST_IDLE:
                cmd = in_valid ? CMD_LOAD : CMD_NOP;
            ST_EXEC:
            begin
                case (status.op)
                    OP_PUSH:    cmd = status.full  ? CMD_FAIL : CMD_PUSH;
                    OP_POP:     cmd = status.empty ? CMD_FAIL : CMD_POP;
                    OP_POP_MAX: cmd = (status.empty || status.max_empty) ? CMD_FAIL
                                                                         : CMD_POP_MAX;
                    default:    cmd = CMD_NOP;
                endcase
            end
            ST_SCAN_RD:
                cmd = CMD_SCAN_RD;
            ST_SCAN_CMP:
                cmd = status.scan_hit ? CMD_NOP : CMD_SCAN_NEXT;
            ST_SHIFT_RD:
                cmd = status.shift_more ? CMD_SHIFT_RD : CMD_SHIFT_END;
            ST_SHIFT_WR:
                cmd = CMD_SHIFT_WR;
            ST_TOP_RD:
                cmd = CMD_TOP_RD;
            ST_DONE:
                cmd = capture ? CMD_CAPTURE : CMD_NOP;
            default:
                cmd = CMD_NOP;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef ASSERT_OFF
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_EXEC))
        else $error("accepted beat did not enter execute");

    a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_valid_reg && !out_ready) |=> (state_reg == ST_DONE))
        else $error("result captured over an unread beat");

    a_capture_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == CMD_CAPTURE) |=> out_valid_reg)
        else $error("captured result not presented");
`endif

endmodule

FILE: src/mst_dp.sv
// Datapath for the max-tracking stack: value and running-max stores, counts, scan index
// and result register. Depends on mst_pkg; driven by mst_ctrl commands.
module mst_dp #(
    parameter int STACK_DEPTH = mst_pkg::DEF_STACK_DEPTH
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  mst_pkg::cmd_t                         cmd,
    output mst_pkg::status_t                      status,
    input  logic [1:0]                            op,
    input  logic signed [mst_pkg::DATA_W-1:0]     push_value,
    output logic signed [mst_pkg::DATA_W-1:0]     removed_value,
    output logic signed [mst_pkg::DATA_W-1:0]     top_value,
    output logic signed [mst_pkg::DATA_W-1:0]     max_value,
    output logic [mst_pkg::ENTRY_COUNT_W-1:0]     entry_count,
    output logic                                  is_empty,
    output logic                                  error
);
    import mst_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);
    localparam logic [CW-1:0] TWO_C   = CW'(2);

    logic [DATA_W-1:0] vs_mem [STACK_DEPTH];
    logic [DATA_W-1:0] rm_mem [STACK_DEPTH];

    logic [1:0]        op_reg;
    logic [DATA_W-1:0] pv_reg;
    logic [CW-1:0]     vc_reg, vc_next;
    logic [CW-1:0]     mc_reg, mc_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic [DATA_W-1:0] removed_reg, removed_next;
    logic              err_reg, err_next;
    logic [DATA_W-1:0] vs_rd_reg;
    logic [DATA_W-1:0] rm_rd_reg;

    logic [DATA_W-1:0]        removed_out_reg, top_out_reg, max_out_reg;
    logic [ENTRY_COUNT_W-1:0] count_out_reg;
    logic                     empty_out_reg, err_out_reg;

    logic              vs_we, vs_re, rm_we, rm_re;
    logic [AW-1:0]     vs_waddr, vs_raddr, rm_waddr, rm_raddr;
    logic [DATA_W-1:0] vs_wdata;
    logic [DATA_W-1:0] cand;
    logic              rm_take;
    logic [CW-1:0]     vc_dec, mc_dec, mc_dec2, idx_ext;
    logic [AW-1:0]     idx_inc;
    logic              full, empty, max_empty, max_room;
    logic [CW+ENTRY_COUNT_W-1:0] vc_wide;

    assign vc_dec    = vc_reg - ONE_C;
    assign mc_dec    = mc_reg - ONE_C;
    assign mc_dec2   = mc_reg - TWO_C;
    assign idx_ext   = CW'(idx_reg);
    assign idx_inc   = idx_reg + AW'(1);
    assign full      = (vc_reg == DEPTH_C);
    assign empty     = (vc_reg == '0);
    assign max_empty = (mc_reg == '0);
    assign max_room  = (mc_reg != DEPTH_C);
    assign vc_wide   = (CW+ENTRY_COUNT_W)'(vc_reg);

    // candidate for the running-max stack: new value on push, shifted value on rebuild
    assign cand    = (cmd == CMD_SHIFT_WR) ? vs_rd_reg : pv_reg;
    assign rm_take = max_room && (max_empty || ($signed(cand) >= $signed(rm_rd_reg)));

    assign status.op         = op_t'(op_reg);
    assign status.full       = full;
    assign status.empty      = empty;
    assign status.max_empty  = max_empty;
    assign status.scan_hit   = (vs_rd_reg == removed_reg) || (idx_reg == '0);
    assign status.shift_more = (idx_ext + ONE_C) < vc_reg;

    always_comb
    begin
        vc_next      = vc_reg;
        mc_next      = mc_reg;
        idx_next     = idx_reg;
        removed_next = removed_reg;
        err_next     = err_reg;
        vs_we        = 1'b0;
        vs_waddr     = vc_reg[AW-1:0];
        vs_wdata     = pv_reg;
        vs_re        = 1'b0;
        vs_raddr     = idx_reg;
        rm_we        = 1'b0;
        rm_waddr     = mc_reg[AW-1:0];
        rm_re        = 1'b0;
        rm_raddr     = mc_dec[AW-1:0];
        case (cmd)
            CMD_LOAD:
            begin
                removed_next = '0;
                err_next     = 1'b0;
            end
            CMD_PUSH:
            begin
                vs_we   = 1'b1;
                vc_next = vc_reg + ONE_C;
                if (rm_take)
                begin
                    rm_we   = 1'b1;
                    mc_next = mc_reg + ONE_C;
                end
            end
            CMD_POP:
            begin
                removed_next = vs_rd_reg;
                vc_next      = vc_dec;
                if (!max_empty && vs_rd_reg == rm_rd_reg)
                    mc_next = mc_dec;
            end
            CMD_POP_MAX:
            begin
                // max leaves; fetch the new running-max top for the rebuild
                removed_next = rm_rd_reg;
                mc_next      = mc_dec;
                idx_next     = vc_dec[AW-1:0];
                rm_re        = 1'b1;
                rm_raddr     = mc_dec2[AW-1:0];
            end
            CMD_FAIL:
                err_next = 1'b1;
            CMD_SCAN_RD:
            begin
                vs_re    = 1'b1;
                vs_raddr = idx_reg;
            end
            CMD_SCAN_NEXT:
                idx_next = idx_reg - AW'(1);
            CMD_SHIFT_RD:
            begin
                vs_re    = 1'b1;
                vs_raddr = idx_inc;
            end
            CMD_SHIFT_WR:
            begin
                // close the gap and re-offer the moved value to the max stack
                vs_we    = 1'b1;
                vs_waddr = idx_reg;
                vs_wdata = vs_rd_reg;
                idx_next = idx_inc;
                if (rm_take)
                begin
                    rm_we   = 1'b1;
                    mc_next = mc_reg + ONE_C;
                end
            end
            CMD_SHIFT_END:
                vc_next = vc_dec;
            CMD_TOP_RD:
            begin
                vs_re    = 1'b1;
                vs_raddr = vc_dec[AW-1:0];
                rm_re    = 1'b1;
                rm_raddr = mc_dec[AW-1:0];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg <= '0;
            mc_reg <= '0;
        end
        else
        begin
            vc_reg <= vc_next;
            mc_reg <= mc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd == CMD_LOAD)
        begin
            op_reg <= op;
            pv_reg <= push_value;
        end
        idx_reg     <= idx_next;
        removed_reg <= removed_next;
        err_reg     <= err_next;
    end

    always_ff @(posedge clk)
    begin
        if (vs_we)
            vs_mem[vs_waddr] <= vs_wdata;
        if (vs_re)
            vs_rd_reg <= vs_mem[vs_raddr];
    end

    // read register also follows writes, so it holds the running-max top after each write
    always_ff @(posedge clk)
    begin
        if (rm_we)
            rm_mem[rm_waddr] <= cand;
        if (rm_we)
            rm_rd_reg <= cand;
        else if (rm_re)
            rm_rd_reg <= rm_mem[rm_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd == CMD_CAPTURE)
        begin
            removed_out_reg <= removed_reg;
            top_out_reg     <= empty ? '0 : vs_rd_reg;
            max_out_reg     <= max_empty ? '0 : rm_rd_reg;
            count_out_reg   <= vc_wide[ENTRY_COUNT_W-1:0];
            empty_out_reg   <= empty;
            err_out_reg     <= err_reg;
        end
    end

    assign removed_value = removed_out_reg;
    assign top_value     = top_out_reg;
    assign max_value     = max_out_reg;
    assign entry_count   = count_out_reg;
    assign is_empty      = empty_out_reg;
    assign error         = err_out_reg;

`ifndef ASSERT_OFF
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == CMD_PUSH) |-> !full)
        else $error("push issued on full stack");

    a_remove_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == CMD_POP || cmd == CMD_POP_MAX) |-> !empty)
        else $error("removal issued on empty stack");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (vc_reg <= DEPTH_C) && (mc_reg <= DEPTH_C))
        else $error("stack count beyond depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == CMD_PUSH) |=> (vc_reg == $past(vc_reg) + ONE_C))
        else $error("push did not grow the stack");
`endif

endmodule

FILE: src/max_tracking_stack.sv
// Top level of the max-tracking stack: bounded signed stack with running maximum.
// Depends on mst_pkg, mst_ctrl and mst_dp.
//
//   beat     | handshake           | payload
//   ---------+---------------------+--------------------------------------------------
//   request  | in_valid / in_ready | op, push_value
//   result   | out_valid/out_ready | removed_value, top_value, max_value, entry_count,
//            |                     | is_empty, error
//
// Push, pop, peek and any error go from one accepted request to the next through accept,
// execute, read back of both stack tops and capture into the result register.
// Pop maximum also walks the value store: each entry above the removed one is read once
// by the scan down and again by the shift.
// In the datapath, reset clears both counts only; the stores need no clearing pass.
// A waiting result never blocks the next request; a new result waits only while the
// previous one is still unread.
module max_tracking_stack #(
    parameter int STACK_DEPTH = mst_pkg::DEF_STACK_DEPTH
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [1:0]                            op,
    input  logic signed [mst_pkg::DATA_W-1:0]     push_value,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [mst_pkg::DATA_W-1:0]     removed_value,
    output logic signed [mst_pkg::DATA_W-1:0]     top_value,
    output logic signed [mst_pkg::DATA_W-1:0]     max_value,
    output logic [mst_pkg::ENTRY_COUNT_W-1:0]     entry_count,
    output logic                                  is_empty,
    output logic                                  error
);
    import mst_pkg::*;

    cmd_t    cmd;
    status_t status;

    // sequencer: one command per cycle to the datapath
    mst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // stores, counts and result register
    mst_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .op            (op),
        .push_value    (push_value),
        .removed_value (removed_value),
        .top_value     (top_value),
        .max_value     (max_value),
        .entry_count   (entry_count),
        .is_empty      (is_empty),
        .error         (error)
    );

endmodule

FILE: dv/tb.sv
// Self-checking bench for max_tracking_stack: push, pop, pop-max and peek beats
// checked against an in-bench stack model. Depends on mst_pkg and the RTL only.
module tb;
    import mst_pkg::*;

    localparam int DEPTH        = DEF_STACK_DEPTH;
    localparam int RANDOM_REQS  = 600;
    // slowest beat is a pop-max at the bottom of a full stack;
    // add stalls on both sides and take it several times over
    localparam int CYCLE_LIMIT  = 800_000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        op_t                      op;
        logic signed [DATA_W-1:0] value;
        bit                       hold;     // wait for all results before sending
    } stack_req_t;

    typedef struct {
        logic signed [DATA_W-1:0]  removed;
        logic signed [DATA_W-1:0]  top;
        logic signed [DATA_W-1:0]  maxv;
        logic [ENTRY_COUNT_W-1:0]  count;
        logic                      empty;
        logic                      err;
    } stack_result_t;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic [1:0]                op;
    logic signed [DATA_W-1:0]  push_value;
    logic                      out_valid;
    logic                      out_ready;
    logic signed [DATA_W-1:0]  removed_value;
    logic signed [DATA_W-1:0]  top_value;
    logic signed [DATA_W-1:0]  max_value;
    logic [ENTRY_COUNT_W-1:0]  entry_count;
    logic                      is_empty;
    logic                      error;

    stack_req_t    req_q[$];        // requests not yet accepted
    stack_result_t result_q[$];     // predicted results not yet seen
    int            total_reqs  = 0;
    int            reqs_taken  = 0;
    int            fail_cnt    = 0;
    int            cycle_cnt   = 0;
    int            gen_depth   = 0; // stack depth as seen by the generator
    bit            beat_taken  = 1'b0;

    // model state: value stack plus stack of running maxima
    logic signed [DATA_W-1:0] model_vals[DEPTH];
    logic signed [DATA_W-1:0] model_maxes[DEPTH];
    int                       model_nvals = 0;
    int                       model_nmax  = 0;

    max_tracking_stack #(
        .STACK_DEPTH(DEPTH)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .push_value   (push_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .removed_value(removed_value),
        .top_value    (top_value),
        .max_value    (max_value),
        .entry_count  (entry_count),
        .is_empty     (is_empty),
        .error        (error)
    );

    always #2 clk = ~clk;

    // A value joins the running-max stack when it is not below the current max and there is room.
    function automatic void track_max(input logic signed [DATA_W-1:0] v);
        if (model_nmax == 0 || v >= model_maxes[model_nmax-1])
        begin
            if (model_nmax < DEPTH)
            begin
                model_maxes[model_nmax] = v;
                model_nmax++;
            end
        end
    endfunction

    // Apply one request to the model and return the result beat it should produce.
    function automatic stack_result_t apply_request(input op_t req_op,
                                                    input logic signed [DATA_W-1:0] v);
        stack_result_t            r;
        logic signed [DATA_W-1:0] top_max;
        int                       i;
        int                       j;
        r.removed = '0;
        r.err     = 1'b0;
        case (req_op)
            OP_PUSH:
            begin
                if (model_nvals >= DEPTH)
                    r.err = 1'b1;
                else
                begin
                    track_max(v);
                    model_vals[model_nvals] = v;
                    model_nvals++;
                end
            end
            OP_POP:
            begin
                if (model_nvals == 0)
                    r.err = 1'b1;
                else
                begin
                    r.removed = model_vals[model_nvals-1];
                    if (model_nmax > 0 && r.removed == model_maxes[model_nmax-1])
                        model_nmax--;
                    model_nvals--;
                end
            end
            OP_POP_MAX:
            begin
                if (model_nvals == 0 || model_nmax == 0)
                    r.err = 1'b1;
                else
                begin
                    // topmost copy of the max goes; entries above slide down and
                    // are re-offered to the running-max stack
                    top_max = model_maxes[model_nmax-1];
                    i = model_nvals - 1;
                    while (i > 0 && model_vals[i] != top_max)
                        i--;
                    r.removed = top_max;
                    model_nmax--;
                    for (j = i; j + 1 < model_nvals; j++)
                        model_vals[j] = model_vals[j+1];
                    model_nvals--;
                    for (j = i; j < model_nvals; j++)
                        track_max(model_vals[j]);
                end
            end
            default:
            begin
            end
        endcase
        r.top   = (model_nvals != 0) ? model_vals[model_nvals-1] : '0;
        r.maxv  = (model_nmax != 0) ? model_maxes[model_nmax-1] : '0;
        r.count = ENTRY_COUNT_W'(model_nvals);
        r.empty = (model_nvals == 0);
        return r;
    endfunction

    function automatic void check_field(input string name,
                                        input logic [DATA_W-1:0] want,
                                        input logic [DATA_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_cnt++;
        end
    endfunction

    // Values skew toward a narrow band so equal maxima turn up often.
    function automatic logic signed [DATA_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return DATA_W'(int'($urandom_range(0, 8)) - 4);
        if (roll < 55)
        begin
            case ($urandom_range(0, 3))
                0:       return 32'sh7fff_ffff;
                1:       return 32'sh8000_0000;
                2:       return -32'sd1;
                default: return 32'sd0;
            endcase
        end
        return $urandom();
    endfunction

    function automatic void add_req(input op_t req_op, input logic signed [DATA_W-1:0] v);
        stack_req_t r;
        r.op    = req_op;
        r.value = v;
        r.hold  = 1'b0;
        req_q.insert(req_q.size(), r);
        case (req_op)
            OP_PUSH:
            begin
                if (gen_depth < DEPTH)
                    gen_depth++;
            end
            OP_POP, OP_POP_MAX:
            begin
                if (gen_depth > 0)
                    gen_depth--;
            end
            default:
            begin
            end
        endcase
    endfunction

    // Monitor: the request beat feeds the model, the result beat is checked
    // field by field against the oldest prediction.
    always @(posedge clk)
    begin : monitor
        stack_result_t want;
        beat_taken <= in_valid && in_ready;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                result_q.insert(result_q.size(), apply_request(op_t'(op), push_value));
                void'(req_q.pop_front());
                reqs_taken++;
            end
            if (out_valid && out_ready)
            begin
                if (result_q.size() == 0)
                begin
                    $error("result beat with no prediction pending");
                    fail_cnt++;
                end
                else
                begin
                    want = result_q.pop_front();
                    check_field("removed_value", want.removed, removed_value);
                    check_field("top_value", want.top, top_value);
                    check_field("max_value", want.maxv, max_value);
                    check_field("entry_count", DATA_W'(want.count), DATA_W'(entry_count));
                    check_field("is_empty", DATA_W'(want.empty), DATA_W'(is_empty));
                    check_field("error", DATA_W'(want.err), DATA_W'(error));
                end
            end
        end
    end

    // Driver: three idle phases by progress through the request list. Phase 0
    // starves the receiver, phase 1 the sender, phase 2 runs flat out.
    always @(negedge clk)
    begin : driver
        int phase;
        int tx_idle;
        int rx_idle;
        phase   = (reqs_taken * 3 < total_reqs) ? 0 :
                  (reqs_taken * 3 < 2 * total_reqs) ? 1 : 2;
        tx_idle = (phase == 0) ? 24 : (phase == 1) ? 63 : 0;
        rx_idle = (phase == 0) ? 63 : (phase == 1) ? 24 : 0;
        out_ready <= ($urandom_range(0, 99) >= rx_idle);
        if (!rst_n)
            in_valid <= 1'b0;
        else if (in_valid && !beat_taken)
        begin
            // beat still pending: hold valid and payload
        end
        else if (req_q.size() == 0 ||
                 (req_q[0].hold && result_q.size() != 0) ||
                 $urandom_range(0, 99) < tx_idle)
            in_valid <= 1'b0;
        else
        begin
            in_valid   <= 1'b1;
            op         <= req_q[0].op;
            push_value <= req_q[0].value;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    initial
    begin : stimulus
        int directed_n;
        int seg;
        int roll;
        clk        = 1'b0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        op         = OP_PEEK;
        push_value = '0;
        out_ready  = 1'b0;

        // Directed: empty-stack errors, extreme values, equal maxima, a pop-max
        // that has to scan all the way to the bottom entry, then drain to empty.
        add_req(OP_PEEK, 32'sd0);
        add_req(OP_POP, 32'sd0);
        add_req(OP_POP_MAX, -32'sd1);
        add_req(OP_PUSH, 32'sh7fff_ffff);
        add_req(OP_PUSH, 32'sh8000_0000);
        add_req(OP_PEEK, 32'sh5555_5555);
        add_req(OP_PUSH, -32'sd1);
        add_req(OP_PUSH, 32'sd0);
        add_req(OP_PUSH, 32'sd5);
        add_req(OP_PUSH, 32'sd5);
        add_req(OP_PUSH, 32'sd3);
        add_req(OP_POP_MAX, 32'shaaaa_aaaa);
        add_req(OP_PUSH, 32'sd5);
        add_req(OP_POP_MAX, 32'sd0);
        add_req(OP_POP_MAX, 32'sd0);
        add_req(OP_POP_MAX, 32'sd0);
        add_req(OP_PEEK, 32'sd0);
        add_req(OP_POP, 32'sd0);
        add_req(OP_POP, 32'sd0);
        add_req(OP_POP, 32'sd0);
        add_req(OP_POP, 32'sd0);
        add_req(OP_POP, 32'sd0);
        add_req(OP_POP_MAX, 32'sd0);
        directed_n = req_q.size();

        // Random: runs that fill to full and push past it, runs that drain to
        // empty and keep removing, and mixed runs in between.
        while (req_q.size() < directed_n + RANDOM_REQS)
        begin
            seg = $urandom_range(0, 9);
            if (seg < 2)
            begin
                while (gen_depth < DEPTH)
                    add_req(OP_PUSH, pick_value());
                repeat ($urandom_range(1, 3))
                    add_req(OP_PUSH, pick_value());
            end
            else if (seg < 4)
            begin
                while (gen_depth > 0)
                    add_req($urandom_range(0, 1) ? OP_POP : OP_POP_MAX, pick_value());
                repeat ($urandom_range(1, 2))
                    add_req(op_t'($urandom_range(1, 2)), pick_value());
            end
            else
            begin
                repeat ($urandom_range(10, 60))
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 45)
                        add_req(OP_PUSH, pick_value());
                    else if (roll < 65)
                        add_req(OP_POP, pick_value());
                    else if (roll < 90)
                        add_req(OP_POP_MAX, pick_value());
                    else
                        add_req(OP_PEEK, pick_value());
                end
            end
        end
        total_reqs = req_q.size();
        // sender drains the block completely at each idle-phase change
        req_q[total_reqs / 3].hold       = 1'b1;
        req_q[(2 * total_reqs) / 3].hold = 1'b1;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (req_q.size() != 0 || result_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_cnt == 0 && result_q.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
